>>> design/hgns_pkg.sv
package hgns_pkg;

   localparam int MAX_POINTS_DEF  = 64;
   localparam int MAX_RES_DEF     = 16;
   localparam int MAX_MATCHES_DEF = 64;

   localparam int COORD_W    = 32;
   localparam int SPACING_W  = 31;
   localparam int RADIUS_W   = 31;
   localparam int RES_W      = 5;
   localparam int CMD_W      = 2;
   localparam int KIND_W     = 2;
   localparam int IDX_W      = 6;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 31;

   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [KIND_W-1:0] KIND_DONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MATCH   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NOMATCH = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FULL    = 2'd3;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPACING = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_RES_X   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_RES_Y   = 2'd2;

   localparam logic [SPACING_W-1:0] SPACING_RST = 31'd65536;
   localparam logic [RES_W-1:0]     RES_RST     = 5'd16;

   typedef enum logic [4:0] {
      S_IDLE, S_DECODE, S_DSTART, S_DWAIT,
      S_AKEY, S_AWR1, S_AWR2,
      S_QKEY, S_QHEAD, S_NEXTB, S_PREAD, S_PCHK,
      S_MUL1, S_MUL2, S_MUL3, S_CMP, S_ADV, S_FIN, S_EMIT
   } state_type;

endpackage

>>> design/hgns_div.sv
module hgns_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [hgns_pkg::COORD_W-1:0]  dividend,
   input  logic [hgns_pkg::SPACING_W-1:0]       divisor,
   output logic                                 done,
   output logic signed [hgns_pkg::COORD_W-1:0]  quotient,
   output logic [hgns_pkg::SPACING_W-1:0]       remainder
);
   import hgns_pkg::*;

   logic                    busy_ff;
   logic                    done_ff;
   logic [4:0]              cnt_ff;
   logic                    neg_ff;
   logic [SPACING_W-1:0]    div_ff;
   logic [COORD_W-1:0]      quo_ff;
   logic [SPACING_W-1:0]    rem_ff;
   logic [COORD_W-1:0]      trial;
   logic [COORD_W-1:0]      diff;
   logic                    ge;
   logic                    rem_nz;

   assign trial = {rem_ff, quo_ff[COORD_W-1]};
   assign ge    = trial >= {1'b0, div_ff};
   assign diff  = trial - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 5'd0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // one quotient bit a cycle on the magnitude; floor sign fix at the end
   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff <= dividend[COORD_W-1];
         div_ff <= divisor;
         quo_ff <= dividend[COORD_W-1] ? COORD_W'(-dividend) : dividend;
         rem_ff <= '0;
         cnt_ff <= 5'd31;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[SPACING_W-1:0] : trial[SPACING_W-1:0];
         quo_ff <= {quo_ff[COORD_W-2:0], ge};
         cnt_ff <= cnt_ff - 5'd1;
      end
   end

   assign rem_nz    = rem_ff != '0;
   assign done      = done_ff;
   assign quotient  = !neg_ff ? quo_ff : (rem_nz ? ~quo_ff : COORD_W'(-quo_ff));
   assign remainder = (!neg_ff || !rem_nz) ? rem_ff : div_ff - rem_ff;

endmodule

>>> design/hash_grid_neighbor_search_2d_unit.sv
// Clear and unused commands go straight to the output. Add makes four passes through
// the shared serial divider (two floor divisions, two wraps), then writes the point.
// Query makes the same passes, then reads each bucket and each visited point, with the
// shared squaring multiplier for points in the bounding box; it may wait on the output.
// One item at a time: the next is taken once the last result is in the output register.
// Reset (synchronous) restores the register defaults, empties all buckets, count zero.
module hash_grid_neighbor_search_2d_unit #(
   parameter int MAX_POINTS  = hgns_pkg::MAX_POINTS_DEF,
   parameter int MAX_RES     = hgns_pkg::MAX_RES_DEF,
   parameter int MAX_MATCHES = hgns_pkg::MAX_MATCHES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [hgns_pkg::CMD_W-1:0]            req_cmd,
   input  logic signed [hgns_pkg::COORD_W-1:0]   req_coord_x,
   input  logic signed [hgns_pkg::COORD_W-1:0]   req_coord_y,
   input  logic [hgns_pkg::RADIUS_W-1:0]         req_radius,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [hgns_pkg::KIND_W-1:0]           rsp_kind,
   output logic [hgns_pkg::IDX_W-1:0]            rsp_match_index,
   output logic signed [hgns_pkg::COORD_W-1:0]   rsp_match_x,
   output logic signed [hgns_pkg::COORD_W-1:0]   rsp_match_y,
   output logic                                  rsp_last,
   output logic                                  rsp_truncated,
   input  logic                                  csr_we,
   input  logic [hgns_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [hgns_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import hgns_pkg::*;

   localparam int PW     = $clog2(MAX_POINTS);
   localparam int CW     = $clog2(MAX_POINTS + 1);
   localparam int NB     = MAX_RES * MAX_RES;
   localparam int KW     = (NB > 1) ? $clog2(NB) : 1;
   localparam int MW     = $clog2(MAX_MATCHES + 1);
   localparam int KSUM_W = 2 * RES_W;

   state_type state_ff, state_in;

   // configuration
   logic [SPACING_W-1:0] spacing_ff;
   logic [RES_W-1:0]     resx_ff, resy_ff;
   logic [SPACING_W-1:0] s_eff;
   logic [RES_W-1:0]     rx_eff, ry_eff;

   // latched item
   logic [CMD_W-1:0]          cmd_ff;
   logic signed [COORD_W-1:0] x_ff, y_ff;
   logic [RADIUS_W-1:0]       rad_ff;

   // cell arithmetic
   logic [1:0]                dsel_ff;
   logic signed [COORD_W-1:0] cx_ff, cy_ff;
   logic                      sx_ff, sy_ff;
   logic [RES_W-1:0]          mx_ff, my_ff;
   logic [RES_W-1:0]          nmx, nmy, wx, wy;
   logic [KSUM_W-1:0]         key_sum;
   logic [KW-1:0]             key;
   logic [KW-1:0]             key_ff;
   logic [1:0]                vi_ff;

   // divider
   logic                      div_start, div_done;
   logic signed [COORD_W-1:0] div_a, div_q;
   logic [SPACING_W-1:0]      div_b, div_r;

   // storage
   logic [NB-1:0]        bvalid_ff;
   logic [2*PW-1:0]      bmem [NB];
   logic [2*PW-1:0]      brd_ff;
   logic                 hit_ff;
   logic [COORD_W-1:0]   xmem [MAX_POINTS];
   logic [COORD_W-1:0]   ymem [MAX_POINTS];
   logic [PW:0]          nmem [MAX_POINTS];
   logic [COORD_W-1:0]   prx_ff, pry_ff;
   logic [PW:0]          nrd_ff;
   logic [CW-1:0]        count_ff;
   logic [PW-1:0]        idx;
   logic                 full;

   // memory controls
   logic            bmem_we, pt_we, nmem_we, brd_en, prd_en;
   logic [PW-1:0]   nmem_addr;
   logic [PW:0]     nmem_wd;
   logic [2*PW-1:0] bmem_wd;

   // walk
   logic [PW-1:0]          p_ff;
   logic [CW-1:0]          guard_ff;
   logic [CW-1:0]          guard_n;
   logic                   more;
   logic signed [COORD_W:0] dx, dy;
   logic [COORD_W:0]       adx, ady;
   logic                   in_box;
   logic [RADIUS_W-1:0]    adx_ff, ady_ff, mul_a;
   logic [2*RADIUS_W-1:0]  mul_p, prod_ff;
   logic [2*RADIUS_W:0]    acc_ff;
   logic                   is_match;
   logic [MW-1:0]          mcnt_ff;
   logic                   trunc_ff;
   logic                   pend_v_ff;
   logic [IDX_W-1:0]       pend_idx_ff;
   logic [COORD_W-1:0]     pend_x_ff, pend_y_ff;

   // result staging and output register
   logic [KIND_W-1:0]  st_kind_ff;
   logic [IDX_W-1:0]   st_idx_ff;
   logic [COORD_W-1:0] st_x_ff, st_y_ff;
   logic               st_last_ff, st_trunc_ff;
   logic               rsp_free;
   logic               rsp_valid_ff;
   logic [KIND_W-1:0]  rsp_kind_ff;
   logic [IDX_W-1:0]   rsp_idx_ff;
   logic [COORD_W-1:0] rsp_x_ff, rsp_y_ff;
   logic               rsp_last_ff, rsp_trunc_ff;

   function automatic logic [RES_W-1:0] res_eff(input logic [RES_W-1:0] r);
      logic [RES_W-1:0] v;
      if (r == '0) begin
         v = RES_W'(1);
      end else if (int'(r) > MAX_RES) begin
         v = RES_W'(MAX_RES);
      end else begin
         v = r;
      end
      return v;
   endfunction

   assign s_eff  = (spacing_ff == '0) ? SPACING_W'(1) : spacing_ff;
   assign rx_eff = res_eff(resx_ff);
   assign ry_eff = res_eff(resy_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= SPACING_RST;
         resx_ff    <= RES_RST;
         resy_ff    <= RES_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SPACING: spacing_ff <= csr_wdata;
            CSR_RES_X:   resx_ff    <= csr_wdata[RES_W-1:0];
            CSR_RES_Y:   resy_ff    <= csr_wdata[RES_W-1:0];
            default: ;
         endcase
      end
   end

   // divider operands
   always_comb begin
      case (dsel_ff)
         2'd0: begin div_a = x_ff;  div_b = s_eff; end
         2'd1: begin div_a = y_ff;  div_b = s_eff; end
         2'd2: begin div_a = cx_ff; div_b = SPACING_W'(rx_eff); end
         default: begin div_a = cy_ff; div_b = SPACING_W'(ry_eff); end
      endcase
   end

   hgns_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_a),
      .divisor   (div_b),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   // neighbour cells toward the nearer half-cell side, wrapped
   always_comb begin
      if (sx_ff) begin
         nmx = (RES_W'(mx_ff + 1'b1) == rx_eff) ? '0 : RES_W'(mx_ff + 1'b1);
      end else begin
         nmx = (mx_ff == '0) ? RES_W'(rx_eff - 1'b1) : RES_W'(mx_ff - 1'b1);
      end
      if (sy_ff) begin
         nmy = (RES_W'(my_ff + 1'b1) == ry_eff) ? '0 : RES_W'(my_ff + 1'b1);
      end else begin
         nmy = (my_ff == '0) ? RES_W'(ry_eff - 1'b1) : RES_W'(my_ff - 1'b1);
      end
      case (vi_ff)
         2'd0: begin wx = mx_ff; wy = my_ff; end
         2'd1: begin wx = mx_ff; wy = nmy;   end
         2'd2: begin wx = nmx;   wy = my_ff; end
         default: begin wx = nmx; wy = nmy;  end
      endcase
      key_sum = KSUM_W'(wy) * KSUM_W'(rx_eff) + KSUM_W'(wx);
      key     = KW'(key_sum);
   end

   assign idx  = count_ff[PW-1:0];
   assign full = count_ff == CW'(MAX_POINTS);

   // distance check
   assign dx     = {prx_ff[COORD_W-1], prx_ff} - {x_ff[COORD_W-1], x_ff};
   assign dy     = {pry_ff[COORD_W-1], pry_ff} - {y_ff[COORD_W-1], y_ff};
   assign adx    = dx[COORD_W] ? (COORD_W+1)'(-dx) : dx;
   assign ady    = dy[COORD_W] ? (COORD_W+1)'(-dy) : dy;
   assign in_box = (adx <= {2'b00, rad_ff}) && (ady <= {2'b00, rad_ff});

   always_comb begin
      case (state_ff)
         S_MUL1:  mul_a = adx_ff;
         S_MUL2:  mul_a = ady_ff;
         default: mul_a = rad_ff;
      endcase
   end
   assign mul_p    = mul_a * mul_a;
   assign is_match = acc_ff <= {1'b0, prod_ff};

   assign guard_n  = guard_ff + 1'b1;
   assign more     = nrd_ff[PW] && (guard_n < CW'(MAX_POINTS));
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_DECODE;
         S_DECODE: begin
            case (cmd_ff)
               CMD_ADD:   state_in = full ? S_EMIT : S_DSTART;
               CMD_QUERY: state_in = S_DSTART;
               default:   state_in = S_EMIT;
            endcase
         end
         S_DSTART: state_in = S_DWAIT;
         S_DWAIT: begin
            if (div_done) begin
               if (dsel_ff != 2'd3) begin
                  state_in = S_DSTART;
               end else begin
                  state_in = (cmd_ff == CMD_ADD) ? S_AKEY : S_QKEY;
               end
            end
         end
         S_AKEY:  state_in = S_AWR1;
         S_AWR1:  state_in = S_AWR2;
         S_AWR2:  state_in = S_EMIT;
         S_QKEY:  state_in = S_QHEAD;
         S_QHEAD: state_in = hit_ff ? S_PREAD : S_NEXTB;
         S_NEXTB: state_in = (vi_ff == 2'd3) ? S_FIN : S_QKEY;
         S_PREAD: state_in = S_PCHK;
         S_PCHK:  state_in = in_box ? S_MUL1 : S_ADV;
         S_MUL1:  state_in = S_MUL2;
         S_MUL2:  state_in = S_MUL3;
         S_MUL3:  state_in = S_CMP;
         S_CMP: begin
            if (!is_match) begin
               state_in = S_ADV;
            end else if (mcnt_ff >= MW'(MAX_MATCHES)) begin
               state_in = S_FIN;
            end else begin
               state_in = pend_v_ff ? S_EMIT : S_ADV;
            end
         end
         S_ADV:  state_in = more ? S_PREAD : S_NEXTB;
         S_FIN:  state_in = S_EMIT;
         S_EMIT: if (rsp_free) state_in = st_last_ff ? S_IDLE : S_ADV;
         default: state_in = S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = state_ff != S_IDLE;
      div_start = state_ff == S_DSTART;
      brd_en    = (state_ff == S_AKEY) || (state_ff == S_QKEY);
      prd_en    = state_ff == S_PREAD;
      pt_we     = state_ff == S_AWR1;
      bmem_we   = state_ff == S_AWR1;
      bmem_wd   = hit_ff ? {brd_ff[2*PW-1:PW], idx} : {idx, idx};
      nmem_we   = (state_ff == S_AWR1) || (state_ff == S_AWR2 && hit_ff);
      if (state_ff == S_AWR1) begin
         nmem_addr = idx;
         nmem_wd   = {1'b0, idx};
      end else begin
         nmem_addr = brd_ff[PW-1:0];
         nmem_wd   = {1'b1, idx};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (bmem_we) bmem[key_ff] <= bmem_wd;
      if (brd_en) brd_ff <= bmem[key];
      if (pt_we) begin
         xmem[idx] <= x_ff;
         ymem[idx] <= y_ff;
      end
      if (nmem_we) nmem[nmem_addr] <= nmem_wd;
      if (prd_en) begin
         prx_ff <= xmem[p_ff];
         pry_ff <= ymem[p_ff];
         nrd_ff <= nmem[p_ff];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bvalid_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (state_ff == S_DECODE && cmd_ff == CMD_CLEAR) begin
            bvalid_ff <= '0;
            count_ff  <= '0;
         end
         if (state_ff == S_AWR1) bvalid_ff[key_ff] <= 1'b1;
         if (state_ff == S_AWR2) count_ff <= count_ff + 1'b1;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_valid) begin
         cmd_ff <= req_cmd;
         x_ff   <= req_coord_x;
         y_ff   <= req_coord_y;
         rad_ff <= req_radius;
      end
      case (state_ff)
         S_DECODE: begin
            dsel_ff     <= 2'd0;
            vi_ff       <= 2'd0;
            mcnt_ff     <= '0;
            pend_v_ff   <= 1'b0;
            trunc_ff    <= 1'b0;
            st_kind_ff  <= (cmd_ff == CMD_ADD) ? KIND_FULL : KIND_DONE;
            st_idx_ff   <= '0;
            st_x_ff     <= (cmd_ff == CMD_ADD) ? x_ff : '0;
            st_y_ff     <= (cmd_ff == CMD_ADD) ? y_ff : '0;
            st_last_ff  <= 1'b1;
            st_trunc_ff <= 1'b0;
         end
         S_DWAIT: begin
            if (div_done) begin
               case (dsel_ff)
                  2'd0: begin
                     cx_ff <= div_q;
                     sx_ff <= {div_r, 1'b0} >= {1'b0, s_eff};
                  end
                  2'd1: begin
                     cy_ff <= div_q;
                     sy_ff <= {div_r, 1'b0} >= {1'b0, s_eff};
                  end
                  2'd2: mx_ff <= div_r[RES_W-1:0];
                  default: my_ff <= div_r[RES_W-1:0];
               endcase
               dsel_ff <= dsel_ff + 2'd1;
            end
         end
         S_AKEY, S_QKEY: begin
            key_ff <= key;
            hit_ff <= bvalid_ff[key];
         end
         S_AWR2: begin
            st_kind_ff <= KIND_DONE;
            st_idx_ff  <= IDX_W'(idx);
            st_x_ff    <= x_ff;
            st_y_ff    <= y_ff;
         end
         S_QHEAD: begin
            p_ff     <= brd_ff[2*PW-1:PW];
            guard_ff <= '0;
         end
         S_NEXTB: vi_ff <= vi_ff + 2'd1;
         S_PCHK: begin
            adx_ff <= adx[RADIUS_W-1:0];
            ady_ff <= ady[RADIUS_W-1:0];
         end
         S_MUL1: prod_ff <= mul_p;
         S_MUL2: begin
            acc_ff  <= {1'b0, prod_ff};
            prod_ff <= mul_p;
         end
         S_MUL3: begin
            acc_ff  <= acc_ff + {1'b0, prod_ff};
            prod_ff <= mul_p;
         end
         S_CMP: begin
            if (is_match) begin
               if (mcnt_ff >= MW'(MAX_MATCHES)) begin
                  trunc_ff <= 1'b1;
               end else begin
                  // hold the newest match back until it is known not to be the final one
                  if (pend_v_ff) begin
                     st_kind_ff  <= KIND_MATCH;
                     st_idx_ff   <= pend_idx_ff;
                     st_x_ff     <= pend_x_ff;
                     st_y_ff     <= pend_y_ff;
                     st_last_ff  <= 1'b0;
                     st_trunc_ff <= 1'b0;
                  end
                  pend_v_ff   <= 1'b1;
                  pend_idx_ff <= IDX_W'(p_ff);
                  pend_x_ff   <= prx_ff;
                  pend_y_ff   <= pry_ff;
                  mcnt_ff     <= mcnt_ff + 1'b1;
               end
            end
         end
         S_ADV: begin
            p_ff     <= nrd_ff[PW-1:0];
            guard_ff <= guard_n;
         end
         S_FIN: begin
            st_last_ff <= 1'b1;
            if (pend_v_ff) begin
               st_kind_ff  <= KIND_MATCH;
               st_idx_ff   <= pend_idx_ff;
               st_x_ff     <= pend_x_ff;
               st_y_ff     <= pend_y_ff;
               st_trunc_ff <= trunc_ff;
            end else begin
               st_kind_ff  <= KIND_NOMATCH;
               st_idx_ff   <= '0;
               st_x_ff     <= '0;
               st_y_ff     <= '0;
               st_trunc_ff <= 1'b0;
            end
         end
         default: ;
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_EMIT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_EMIT && rsp_free) begin
         rsp_kind_ff  <= st_kind_ff;
         rsp_idx_ff   <= st_idx_ff;
         rsp_x_ff     <= st_x_ff;
         rsp_y_ff     <= st_y_ff;
         rsp_last_ff  <= st_last_ff;
         rsp_trunc_ff <= st_trunc_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_match_index = rsp_idx_ff;
   assign rsp_match_x     = rsp_x_ff;
   assign rsp_match_y     = rsp_y_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_truncated   = rsp_trunc_ff;

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count past capacity");

   a_match_bound: assert property (@(posedge clock) disable iff (reset)
      mcnt_ff <= MW'(MAX_MATCHES) || state_ff == S_IDLE || state_ff == S_DECODE)
      else $error("match count past limit");

   a_nomatch_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_NOMATCH) |-> rsp_last)
      else $error("no-match word not final");

   a_trunc_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_truncated) |-> (rsp_last && rsp_kind == KIND_MATCH))
      else $error("truncated flag on a non-final word");
`endif

endmodule
